// ===== hdl/grm_pkg.sv =====
// grm_pkg: shared types and constants for the grid ray march column block.
// Used by grid_ray_march_column and grm_checker; depends on nothing.
`default_nettype none
package grm_pkg;

  localparam int MAP_WIDTH_DEF    = 16;
  localparam int MAP_HEIGHT_DEF   = 8;
  localparam int MAX_DISTANCE_DEF = 255;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_WALL_LO  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WALL_HI  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_H    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_TOP  = 3'd5;

  localparam logic [4:0] STEP_RST  = 5'd5;
  localparam logic [7:0] DEPTH_RST = 8'd160;
  localparam logic [5:0] WIN_H_RST = 6'd24;

  // n/10 = (n*RECIP10)>>19 for 16-bit n; n/100 = (n*RECIP100)>>19 for 13-bit n
  localparam logic [15:0] RECIP10  = 16'd52429;
  localparam logic [15:0] RECIP100 = 16'd5243;
  // depth/5 = (depth*205)>>10, depth/3 = (depth*171)>>9 for 8-bit depth
  localparam logic [7:0] RECIP5 = 8'd205;
  localparam logic [7:0] RECIP3 = 8'd171;

  localparam logic [7:0] NEAR_DIST = 8'd20;

  typedef struct packed {
    logic        [10:0] player_x;
    logic        [9:0]  player_y;
    logic signed [7:0]  dir_x;
    logic signed [7:0]  dir_y;
  } in_item_t;

  typedef struct packed {
    logic [7:0] wall_distance;
    logic [1:0] shade_class;
    logic [6:0] ceiling_row;
    logic [6:0] floor_row;
    logic       no_hit;
  } out_item_t;

endpackage
`default_nettype wire

// ===== hdl/grid_ray_march_column.sv =====
// Fixed-step grid ray march for one screen column, one shared multiplier
// under a sequencer. Each march round steps the distance, then per axis
// multiplies and scales the coordinate, then checks the map bounds and cell;
// a round that misses early stops after the step or either axis. A restoring
// divide gives the ceiling term, then the result loads; one ray at a time.
// Reset (rst_n low, synchronous): idle, no result, config at reset values.
`default_nettype none
module grid_ray_march_column #(
  parameter int MAP_WIDTH    = grm_pkg::MAP_WIDTH_DEF,
  parameter int MAP_HEIGHT   = grm_pkg::MAP_HEIGHT_DEF,
  parameter int MAX_DISTANCE = grm_pkg::MAX_DISTANCE_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire grm_pkg::in_item_t              in_data,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output grm_pkg::out_item_t                  out_data,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [grm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [grm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import grm_pkg::*;

  localparam int NUM_W = 14;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_STEP  = 9'b000000010,
    S_MUL_P = 9'b000000100,
    S_MUL_Q = 9'b000001000,
    S_MUL_C = 9'b000010000,
    S_CHECK = 9'b000100000,
    S_NUMER = 9'b001000000,
    S_DIV   = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  logic [63:0] wall_lo_r, wall_lo_nxt;
  logic [63:0] wall_hi_r, wall_hi_nxt;
  logic [4:0]  step_r, step_nxt;
  logic [7:0]  depth_r, depth_nxt;
  logic [5:0]  win_h_r, win_h_nxt;
  logic [5:0]  win_top_r, win_top_nxt;

  logic [10:0]       px_r, px_nxt;
  logic [9:0]        py_r, py_nxt;
  logic signed [7:0] ex_r, ex_nxt;
  logic signed [7:0] ey_r, ey_nxt;
  logic [8:0]        d_r, d_nxt;
  logic              miss_r, miss_nxt;
  logic              axis_r, axis_nxt;
  logic [6:0]        cx_r, cx_nxt;
  logic [31:0]       mul_r, mul_nxt;
  logic [8:0]        rem_r, rem_nxt;
  logic [3:0]        cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;

  logic [15:0]       mul_a, mul_b;
  logic [31:0]       prod;
  logic [4:0]        step_eff;
  logic [8:0]        d_sum;
  logic [7:0]        e_sel;
  logic [7:0]        e_mag;
  logic [10:0]       p0;
  logic [11:0]       q;
  logic [13:0]       s_val;
  logic [6:0]        cy;
  logic [127:0]      wall_map;
  logic [6:0]        wall_idx;
  logic [7:0]        dist_sat;
  logic [7:0]        dist_excess;
  logic [8:0]        den;
  logic [9:0]        rem_trial;
  logic              q_bit;
  logic [5:0]        term;
  logic [7:0]        floor_s;
  logic [15:0]       prod5, prod3;
  logic [5:0]        depth5;
  logic [6:0]        depth3;
  logic [1:0]        shade;

  assign prod      = mul_a * mul_b;
  assign step_eff  = (step_r == 5'd0) ? 5'd1 : step_r;
  assign d_sum     = d_r + {4'b0, step_eff};
  assign e_sel     = axis_r ? ey_r : ex_r;
  assign e_mag     = e_sel[7] ? 8'(~e_sel + 8'd1) : e_sel;
  assign p0        = axis_r ? {1'b0, py_r} : px_r;
  assign q         = mul_r[30:19];
  assign s_val     = e_sel[7] ? ({3'b0, p0} - {2'b0, q}) : ({3'b0, p0} + {2'b0, q});
  assign cy        = mul_r[25:19];
  assign wall_map  = {wall_hi_r, wall_lo_r};
  assign wall_idx  = {cy[2:0], cx_r[3:0]};
  assign dist_sat  = d_r[8] ? 8'd255 : d_r[7:0];
  assign dist_excess = (dist_sat > NEAR_DIST) ? 8'(dist_sat - NEAR_DIST) : 8'd0;
  assign den       = {dist_sat, 1'b0};
  assign rem_trial = {rem_r, mul_r[NUM_W-1]};
  assign q_bit     = (rem_trial >= {1'b0, den});
  assign term      = mul_r[5:0];
  assign floor_s   = {2'b0, win_h_r} - {2'b0, term} - 8'd2;
  assign prod5     = {8'b0, depth_r} * {8'b0, RECIP5};
  assign prod3     = {8'b0, depth_r} * {8'b0, RECIP3};
  assign depth5    = prod5[15:10];
  assign depth3    = prod3[15:9];

  always_comb begin
    priority if (dist_sat <= {2'b0, depth5}) shade = 2'd0;
    else if (dist_sat < {1'b0, depth3})       shade = 2'd1;
    else if (dist_sat < depth_r)              shade = 2'd2;
    else                                      shade = 2'd3;
  end

  assign cfg_ready = 1'b1;

  always_comb begin
    wall_lo_nxt = wall_lo_r;
    wall_hi_nxt = wall_hi_r;
    step_nxt    = step_r;
    depth_nxt   = depth_r;
    win_h_nxt   = win_h_r;
    win_top_nxt = win_top_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_WALL_LO: wall_lo_nxt = cfg_data;
        REG_WALL_HI: wall_hi_nxt = cfg_data;
        REG_STEP:    step_nxt    = cfg_data[4:0];
        REG_DEPTH:   depth_nxt   = cfg_data[7:0];
        REG_WIN_H:   win_h_nxt   = cfg_data[5:0];
        REG_WIN_TOP: win_top_nxt = cfg_data[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    ex_nxt        = ex_r;
    ey_nxt        = ey_r;
    d_nxt         = d_r;
    miss_nxt      = miss_r;
    axis_nxt      = axis_r;
    cx_nxt        = cx_r;
    mul_nxt       = mul_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    mul_a         = 16'd0;
    mul_b         = 16'd0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          px_nxt    = in_data.player_x;
          py_nxt    = in_data.player_y;
          ex_nxt    = in_data.dir_x;
          ey_nxt    = in_data.dir_y;
          d_nxt     = 9'd0;
          miss_nxt  = 1'b0;
          state_nxt = S_STEP;
        end
      end
      S_STEP: begin
        axis_nxt = 1'b0;
        d_nxt    = d_sum;
        if (d_sum > 9'(MAX_DISTANCE)) begin
          miss_nxt  = 1'b1;
          state_nxt = S_NUMER;
        end else begin
          state_nxt = S_MUL_P;
        end
      end
      S_MUL_P: begin
        mul_a   = {8'b0, e_mag};
        mul_b   = {7'b0, d_r};
        mul_nxt = prod;
        if (axis_r) cx_nxt = mul_r[25:19];
        state_nxt = S_MUL_Q;
      end
      S_MUL_Q: begin
        mul_a     = mul_r[15:0];
        mul_b     = RECIP10;
        mul_nxt   = prod;
        state_nxt = S_MUL_C;
      end
      S_MUL_C: begin
        if (s_val[13]) begin
          miss_nxt  = 1'b1;
          state_nxt = S_NUMER;
        end else begin
          mul_a   = {3'b0, s_val[12:0]};
          mul_b   = RECIP100;
          mul_nxt = prod;
          if (axis_r) begin
            state_nxt = S_CHECK;
          end else begin
            axis_nxt  = 1'b1;
            state_nxt = S_MUL_P;
          end
        end
      end
      S_CHECK: begin
        if (cx_r >= 7'(MAP_WIDTH) || cy >= 7'(MAP_HEIGHT)) begin
          miss_nxt  = 1'b1;
          state_nxt = S_NUMER;
        end else if (wall_map[wall_idx]) begin
          state_nxt = S_NUMER;
        end else begin
          state_nxt = S_STEP;
        end
      end
      S_NUMER: begin
        // dividend h*(D-20), zero when the wall is near enough that the term clips
        mul_a     = {10'b0, win_h_r};
        mul_b     = {8'b0, dist_excess};
        mul_nxt   = prod;
        rem_nxt   = 9'd0;
        cnt_nxt   = 4'd0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        rem_nxt = q_bit ? 9'(rem_trial - {1'b0, den}) : rem_trial[8:0];
        mul_nxt = {mul_r[31:NUM_W], mul_r[NUM_W-2:0], q_bit};
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'(NUM_W - 1)) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.wall_distance = dist_sat;
          out_data_nxt.shade_class   = shade;
          out_data_nxt.ceiling_row   = {1'b0, term} + {1'b0, win_top_r};
          out_data_nxt.floor_row     = floor_s[7] ? 7'd0 : floor_s[6:0];
          out_data_nxt.no_hit        = miss_r;
          state_nxt                  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      wall_lo_r   <= 64'd0;
      wall_hi_r   <= 64'd0;
      step_r      <= STEP_RST;
      depth_r     <= DEPTH_RST;
      win_h_r     <= WIN_H_RST;
      win_top_r   <= 6'd0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      wall_lo_r   <= wall_lo_nxt;
      wall_hi_r   <= wall_hi_nxt;
      step_r      <= step_nxt;
      depth_r     <= depth_nxt;
      win_h_r     <= win_h_nxt;
      win_top_r   <= win_top_nxt;
    end
  end

  always_ff @(posedge clk) begin
    px_r       <= px_nxt;
    py_r       <= py_nxt;
    ex_r       <= ex_nxt;
    ey_r       <= ey_nxt;
    d_r        <= d_nxt;
    miss_r     <= miss_nxt;
    axis_r     <= axis_nxt;
    cx_r       <= cx_nxt;
    mul_r      <= mul_nxt;
    rem_r      <= rem_nxt;
    cnt_r      <= cnt_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// ===== hdl/grm_checker.sv =====
// grm_checker: port-level assertions for grid_ray_march_column, with bind.
// Depends on grm_pkg for the result beat type.
`default_nettype none
module grm_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire grm_pkg::out_item_t out_data
);
  import grm_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("block ready right after taking a ray");

  a_dist_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.wall_distance != 8'd0)
    else $error("result beat with zero distance");

  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result beat without a ray in work");

endmodule

bind grid_ray_march_column grm_checker u_grm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire
